### design/waypoint_heading_distance_planner_macros.svh
// ----------------------------------------------------------------------------
// waypoint planner assertion macros
// shared assertion forms for the planner
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_HEADING_DISTANCE_PLANNER_MACROS_SVH
`define WAYPOINT_HEADING_DISTANCE_PLANNER_MACROS_SVH

// implication checked every cycle outside reset
`define WHDP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define WHDP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/whdp_pkg.sv
// ----------------------------------------------------------------------------
// waypoint planner package
// types, constants and tables shared by the planner files
// ----------------------------------------------------------------------------
package whdp_pkg;

  localparam int CordicIterations = 16;
  localparam int IterW = 5;
  localparam int AtanLen = 24;

  localparam logic signed [19:0] PiQ16 = 20'sd205887;
  localparam logic signed [15:0] PiQ13 = 16'sd25736;
  localparam logic signed [16:0] TwoPiQ13 = 17'sd51472;

  localparam logic [1:0] RegDistTol = 2'd0;
  localparam logic [1:0] RegSpinStep = 2'd1;
  localparam logic [1:0] RegMoveStep = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT,
    ST_CORDIC,
    ST_SPIN,
    ST_DIV_SPIN,
    ST_DIV_MOVE,
    ST_OUT
  } state_t;

  function automatic logic [16:0] atan_q16(input logic [IterW-1:0] i);
    logic [16:0] r;
    unique case (i)
      5'd0: r = 17'd51472;
      5'd1: r = 17'd30386;
      5'd2: r = 17'd16055;
      5'd3: r = 17'd8150;
      5'd4: r = 17'd4091;
      5'd5: r = 17'd2047;
      5'd6: r = 17'd1024;
      5'd7: r = 17'd512;
      5'd8: r = 17'd256;
      5'd9: r = 17'd128;
      5'd10: r = 17'd64;
      5'd11: r = 17'd32;
      5'd12: r = 17'd16;
      5'd13: r = 17'd8;
      5'd14: r = 17'd4;
      5'd15: r = 17'd2;
      5'd16: r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

### design/whdp_if.sv
// ----------------------------------------------------------------------------
// planner channel interfaces
// valid and ready channels for goals, results and register writes
// ----------------------------------------------------------------------------
interface whdp_goal_if;
  logic valid;
  logic ready;
  logic signed [31:0] goal_x;
  logic signed [31:0] goal_y;
  logic signed [15:0] goal_heading;
  modport source (output valid, goal_x, goal_y, goal_heading, input ready);
  modport sink (input valid, goal_x, goal_y, goal_heading, output ready);
endinterface

interface whdp_result_if;
  logic valid;
  logic ready;
  logic signed [15:0] heading;
  logic signed [15:0] turn_angle;
  logic [32:0] path_length;
  logic [14:0] spin_ticks;
  logic [32:0] move_ticks;
  modport source (output valid, heading, turn_angle, path_length, spin_ticks,
    move_ticks, input ready);
  modport sink (input valid, heading, turn_angle, path_length, spin_ticks,
    move_ticks, output ready);
endinterface

interface whdp_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/waypoint_heading_distance_planner.sv
// ----------------------------------------------------------------------------
// waypoint heading and distance planner
// range by bitwise square root, bearing by cordic, tick counts by division
// ----------------------------------------------------------------------------
// usage:
//   goal: one waypoint per item (goal_x, goal_y, goal_heading)
//   result: one item per goal with heading, turn, range and tick counts
//   cfg: register writes (tolerance, spin step, move step), while idle
// steps: serial square sum, one-bit-a-step square root, cordic bearing
//   (skipped when the range is under the tolerance), spin angle, then
//   the spin and move divides on the shared restoring divider
// flow: one item at a time; goal.ready is high only when idle, so a new
//   goal is taken only after the last result has been taken
// reset: position and last heading clear, registers take reset values
// stall: the result holds in its output register until taken; the next
//   goal is accepted from the cycle after the result is taken
// ----------------------------------------------------------------------------
`include "waypoint_heading_distance_planner_macros.svh"

module waypoint_heading_distance_planner (
  input logic clk,
  input logic rst,
  whdp_goal_if.sink     goal,
  whdp_result_if.source result,
  whdp_cfg_if.sink      cfg
);
  import whdp_pkg::*;

  state_t state, state_next;

  logic [15:0] dist_tolerance;
  logic [12:0] spin_step;
  logic [15:0] move_step;
  logic signed [31:0] current_x, current_y;
  logic signed [15:0] last_heading;

  logic signed [32:0] dx, dy;
  logic signed [15:0] gh;
  logic [65:0] sumsq;
  logic [33:0] root;
  logic [35:0] rem;
  logic [5:0]  cnt;
  logic signed [51:0] cx, cy;
  logic signed [21:0] cz;
  logic signed [15:0] heading_r, spin_r;
  logic [14:0] spin_ticks_r;

  logic        div_start, div_done;
  logic [32:0] div_numer, div_quot;
  logic [15:0] div_denom;

  assign goal.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign result.valid = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_tolerance <= 16'd655;
      spin_step <= 13'd25;
      move_step <= 16'd197;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        RegDistTol: dist_tolerance <= cfg.data;
        RegSpinStep: spin_step <= cfg.data[12:0];
        RegMoveStep: move_step <= cfg.data;
        default: ;
      endcase
    end
  end

  // absolute differences
  logic [32:0] ax, ay;
  assign ax = dx[32] ? 33'(-dx) : 33'(dx);
  assign ay = dy[32] ? 33'(-dy) : 33'(dy);

  // square sum, msb first, one multiplier bit per cycle
  logic [5:0]  sq_bit;
  logic [32:0] sq_ax, sq_ay;
  assign sq_bit = 6'd32 - cnt;
  assign sq_ax = ax[sq_bit] ? ax : 33'd0;
  assign sq_ay = ay[sq_bit] ? ay : 33'd0;

  logic [35:0] sq_trial;
  assign sq_trial = {root[33:0], 2'b01};

  logic signed [51:0] xs, ys;
  assign xs = cx >>> cnt[IterW-1:0];
  assign ys = cy >>> cnt[IterW-1:0];

  logic signed [21:0] zr;
  logic signed [19:0] zq;
  assign zr = (cz + 22'sd4) >>> 3;
  assign zq = (zr > 22'(PiQ13)) ? 20'(PiQ13) :
              (zr < -22'(PiQ13)) ? -20'(PiQ13) : zr[19:0];

  logic signed [16:0] sp_raw, sp_wrap;
  assign sp_raw = 17'(heading_r) - 17'(last_heading);
  assign sp_wrap = (sp_raw > 17'(PiQ13)) ? sp_raw - TwoPiQ13 :
                   (sp_raw < -17'(PiQ13)) ? sp_raw + TwoPiQ13 : sp_raw;

  logic [35:0] rem_sh;
  assign rem_sh = {rem[33:0], sumsq[65:64]};

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    div_numer = '0;
    div_denom = '0;
    unique case (state)
      ST_IDLE: if (goal.valid) state_next = ST_SQ;
      ST_SQ: if (cnt == 6'd32) state_next = ST_SQRT;
      ST_SQRT: if (cnt == 6'd32) state_next = ST_CORDIC;
      ST_CORDIC: begin
        if ({1'b0, root[32:0]} < {18'd0, dist_tolerance}) state_next = ST_SPIN;
        else if (cnt == 6'(CordicIterations)) state_next = ST_SPIN;
      end
      ST_SPIN: begin
        state_next = ST_DIV_SPIN;
        div_start = 1'b1;
        div_numer = 33'(sp_wrap[16] ? -sp_wrap : sp_wrap);
        div_denom = {3'd0, spin_step};
      end
      ST_DIV_SPIN: if (div_done) begin
        state_next = ST_DIV_MOVE;
        div_start = 1'b1;
        div_numer = root[32:0];
        div_denom = move_step;
      end
      ST_DIV_MOVE: if (div_done) state_next = ST_OUT;
      ST_OUT: if (result.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      current_x <= '0;
      current_y <= '0;
      last_heading <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: if (goal.valid) begin
          dx <= 33'(goal.goal_x) - 33'(current_x);
          dy <= 33'(goal.goal_y) - 33'(current_y);
          gh <= goal.goal_heading;
          current_x <= goal.goal_x;
          current_y <= goal.goal_y;
          cnt <= '0;
          root <= '0;
          rem <= '0;
          sumsq <= '0;
        end
        ST_SQ: begin
          sumsq <= {sumsq[64:0], 1'b0} + {33'd0, sq_ax} + {33'd0, sq_ay};
          cnt <= (cnt == 6'd32) ? 6'd0 : cnt + 6'd1;
        end
        ST_SQRT: begin
          if (rem_sh >= sq_trial) begin
            rem <= rem_sh - sq_trial;
            root <= {root[32:0], 1'b1};
          end else begin
            rem <= rem_sh;
            root <= {root[32:0], 1'b0};
          end
          sumsq <= {sumsq[63:0], 2'b00};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd32) begin
            cnt <= '0;
            if (dx[32]) begin
              cx <= -(52'(dx) <<< 16);
              cy <= -(52'(dy) <<< 16);
              cz <= dy[32] ? -22'(PiQ16) : 22'(PiQ16);
            end else begin
              cx <= 52'(dx) <<< 16;
              cy <= 52'(dy) <<< 16;
              cz <= '0;
            end
          end
        end
        ST_CORDIC: begin
          if ({1'b0, root[32:0]} < {18'd0, dist_tolerance}) heading_r <= gh;
          else if (cnt == 6'(CordicIterations)) begin
            heading_r <= (dx == 33'sd0 && dy == 33'sd0) ? 16'sd0 : zq[15:0];
          end else begin
            if (cy > 52'sd0) begin
              cx <= cx + ys;
              cy <= cy - xs;
              cz <= cz + 22'(atan_q16(cnt[IterW-1:0]));
            end else begin
              cx <= cx - ys;
              cy <= cy + xs;
              cz <= cz - 22'(atan_q16(cnt[IterW-1:0]));
            end
            cnt <= cnt + 6'd1;
          end
        end
        ST_SPIN: begin
          spin_r <= sp_wrap[15:0];
          last_heading <= heading_r;
        end
        ST_DIV_SPIN: if (div_done) spin_ticks_r <= div_quot[14:0];
        ST_DIV_MOVE: if (div_done) result.move_ticks <= div_quot;
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  assign result.heading = heading_r;
  assign result.turn_angle = spin_r;
  assign result.path_length = root[32:0];
  assign result.spin_ticks = spin_ticks_r;

  whdp_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .done  (div_done),
    .quot  (div_quot)
  );

  `WHDP_ASSERT_IMP(a_ready_idle, goal.ready, !result.valid)
  `WHDP_ASSERT_NEXT(a_out_hold, result.valid && !result.ready, result.valid)
  `WHDP_ASSERT_IMP(a_spin_range, result.valid,
    result.turn_angle <= PiQ13 && result.turn_angle >= -PiQ13)
endmodule

### design/whdp_divider.sv
// ----------------------------------------------------------------------------
// planner divider
// restoring divider, one quotient bit per cycle, ceiling result
// ----------------------------------------------------------------------------
module whdp_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] numer,
  input  logic [15:0] denom,
  output logic        done,
  output logic [32:0] quot
);
  import whdp_pkg::*;

  logic [5:0]  count;
  logic        busy;
  logic [32:0] q;
  logic [16:0] rem;
  logic [15:0] d;
  logic [16:0] trial;
  logic [16:0] diff;

  assign trial = {rem[15:0], q[32]};
  assign diff = trial - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 6'd33;
        q <= numer;
        rem <= '0;
        d <= (denom == 16'd0) ? 16'd1 : denom;
      end else if (busy) begin
        if (count == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
          quot <= q + {32'd0, (rem != 17'd0)};
        end else begin
          count <= count - 6'd1;
          if (!diff[16]) begin
            rem <= diff;
            q <= {q[31:0], 1'b1};
          end else begin
            rem <= trial;
            q <= {q[31:0], 1'b0};
          end
        end
      end
    end
  end
endmodule
